/* hw/rtl/grid_test_pattern_generator_core_macros.svh */
// Assertion helpers for the grid pattern generator.
// All checks are clocked on i_clk and are off while i_rst_n is low.
`ifndef GRID_TEST_PATTERN_GENERATOR_CORE_MACROS_SVH
`define GRID_TEST_PATTERN_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define GTPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gtpg assertion failed");

// Next-cycle implication
`define GTPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gtpg assertion failed");

`else

`define GTPG_ASSERT_NOW(label, ante, cons)
`define GTPG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/gtpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gtpg_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CELL_W      = 12;
    localparam int COUNT_W     = 8;
    localparam int COLOR_W     = 32;
    localparam int STEP_W      = 8;
    localparam int BPP_W       = 6;
    localparam int LAYOUT_W    = 30;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CELL_WIDTH     = 3'd0,
        CFG_CELL_HEIGHT    = 3'd1,
        CFG_RECT_COUNT     = 3'd2,
        CFG_FIRST_COLOR    = 3'd3,
        CFG_COLOR_STEP     = 3'd4,
        CFG_DIRECT_MODE    = 3'd5,
        CFG_BITS_PER_PIXEL = 3'd6,
        CFG_CHANNEL_LAYOUT = 3'd7
    } t_cfg_index;

    // All ones below bit 'bits'; 32 and above give a full word.
    function automatic logic [COLOR_W-1:0] low_mask(input logic [BPP_W-1:0] bits);
        logic [COLOR_W-1:0] m;
        if (bits[5]) begin
            m = '1;
        end else begin
            m = (32'd1 << bits[4:0]) - 32'd1;
        end
        return m;
    endfunction

    // One direct-mode channel: extract, add offset*step, wrap, put back in place.
    function automatic logic [COLOR_W-1:0] channel_value(
        input logic [COLOR_W-1:0] first,
        input logic [4:0]         size,
        input logic [4:0]         pos,
        input logic [8:0]         offset,
        input logic [STEP_W-1:0]  step
    );
        logic [COLOR_W-1:0] m;
        logic [16:0]        prod;
        logic [COLOR_W-1:0] v;
        m    = low_mask({1'b0, size});
        prod = 17'(offset) * 17'(step);
        v    = ((first >> pos) + 32'(prod)) & m;
        return v << pos;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/grid_test_pattern_generator_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Grid test pattern generator. Every transaction on the slave stream asks for one
// pixel; the block answers with one master-stream transaction carrying the pixel's
// x and y coordinate and color, walking a rect_count by rect_count grid of
// cell_width by cell_height rectangles cell by cell, and row by row inside a cell.
// tlast marks the last pixel of the frame, after which the walk wraps to the top
// left. A set restart bit starts the walk over at that very pixel. Throughput is
// one pixel per clock unless m_axis_tready stalls it. The color logic (three 9x8
// multipliers in direct mode) sits between the position counters, color sum and output
// register, so a pixel is valid in the cycle after its request. The output
// register is bypassed for ready, so a new request is taken while the previous
// pixel is being taken. Program the configuration registers only while idle.
module grid_test_pattern_generator_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [gtpg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [gtpg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request stream
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [0] restart
    // pixel stream
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output      logic [63:0]                         m_axis_tdata,  // [15:0] pixel_x,
                                                                    // [31:16] pixel_y,
                                                                    // [63:32] pixel_color
    output      logic                                m_axis_tlast   // frame_last
);

    localparam int CW  = gtpg_pkg::COORD_WIDTH;
    localparam int CLW = gtpg_pkg::CELL_W;
    localparam int CNW = gtpg_pkg::COUNT_W;

    // configuration
    logic [CLW-1:0]                    r_cell_width;
    logic [CLW-1:0]                    r_cell_height;
    logic [CNW-1:0]                    r_rect_count;
    logic [gtpg_pkg::COLOR_W-1:0]      r_first_color;
    logic [gtpg_pkg::STEP_W-1:0]       r_color_step;
    logic                              r_direct_mode;
    logic [gtpg_pkg::BPP_W-1:0]        r_bits_per_pixel;
    logic [gtpg_pkg::LAYOUT_W-1:0]     r_channel_layout;

    // walk state
    logic [CLW-1:0]                    r_x_in_cell,   n_x_in_cell;
    logic [CLW-1:0]                    r_y_in_cell,   n_y_in_cell;
    logic [CNW-1:0]                    r_cell_column, n_cell_column;
    logic [CNW-1:0]                    r_cell_row,    n_cell_row;
    logic [CW-1:0]                     r_origin_x,    n_origin_x;
    logic [CW-1:0]                     r_origin_y,    n_origin_y;
    logic [gtpg_pkg::COLOR_W-1:0]      r_index_sum,   n_index_sum;

    // output register
    logic                              r_out_valid;
    logic [CW-1:0]                     r_pixel_x,     n_pixel_x;
    logic [CW-1:0]                     r_pixel_y,     n_pixel_y;
    logic [gtpg_pkg::COLOR_W-1:0]      r_pixel_color, n_pixel_color;
    logic                              r_frame_last,  n_frame_last;

    // current state after a possible restart
    logic [CLW-1:0]                    w_x, w_y;
    logic [CNW-1:0]                    w_col, w_row;
    logic [CW-1:0]                     w_ox, w_oy;
    logic [gtpg_pkg::COLOR_W-1:0]      w_sum;
    logic                              w_restart;
    logic                              w_accept;
    logic                              w_x_end, w_y_end, w_c_end, w_r_end;
    logic [8:0]                        w_diag;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_restart     = s_axis_tdata[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width     <= CLW'(1);
            r_cell_height    <= CLW'(1);
            r_rect_count     <= CNW'(1);
            r_first_color    <= '0;
            r_color_step     <= '0;
            r_direct_mode    <= 1'b0;
            r_bits_per_pixel <= gtpg_pkg::BPP_W'(8);
            r_channel_layout <= '0;
        end else if (i_cfg_we) begin
            case (gtpg_pkg::t_cfg_index'(i_cfg_addr))
                gtpg_pkg::CFG_CELL_WIDTH:     r_cell_width     <= i_cfg_data[CLW-1:0];
                gtpg_pkg::CFG_CELL_HEIGHT:    r_cell_height    <= i_cfg_data[CLW-1:0];
                gtpg_pkg::CFG_RECT_COUNT:     r_rect_count     <= i_cfg_data[CNW-1:0];
                gtpg_pkg::CFG_FIRST_COLOR:    r_first_color    <= i_cfg_data;
                gtpg_pkg::CFG_COLOR_STEP:     r_color_step     <= i_cfg_data[7:0];
                gtpg_pkg::CFG_DIRECT_MODE:    r_direct_mode    <= i_cfg_data[0];
                gtpg_pkg::CFG_BITS_PER_PIXEL: r_bits_per_pixel <= i_cfg_data[5:0];
                gtpg_pkg::CFG_CHANNEL_LAYOUT: r_channel_layout <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // restart clears the walk before this pixel is produced
        w_x   = w_restart ? '0 : r_x_in_cell;
        w_y   = w_restart ? '0 : r_y_in_cell;
        w_col = w_restart ? '0 : r_cell_column;
        w_row = w_restart ? '0 : r_cell_row;
        w_ox  = w_restart ? '0 : r_origin_x;
        w_oy  = w_restart ? '0 : r_origin_y;
        w_sum = w_restart ? '0 : r_index_sum;

        // greater-or-equal so a zero or lowered register ends the run at once
        w_x_end = ({1'b0, w_x} + 13'd1) >= {1'b0, r_cell_width};
        w_y_end = ({1'b0, w_y} + 13'd1) >= {1'b0, r_cell_height};
        w_c_end = ({1'b0, w_col} + 9'd1) >= {1'b0, r_rect_count};
        w_r_end = ({1'b0, w_row} + 9'd1) >= {1'b0, r_rect_count};

        n_pixel_x    = w_ox + CW'(w_x);
        n_pixel_y    = w_oy + CW'(w_y);
        n_frame_last = w_x_end && w_y_end && w_c_end && w_r_end;

        w_diag = {1'b0, w_col} + {1'b0, w_row};
        if (r_direct_mode) begin
            n_pixel_color =
                gtpg_pkg::channel_value(r_first_color, r_channel_layout[4:0],
                    r_channel_layout[9:5], {1'b0, w_col}, r_color_step) |
                gtpg_pkg::channel_value(r_first_color, r_channel_layout[14:10],
                    r_channel_layout[19:15], {1'b0, w_row}, r_color_step) |
                gtpg_pkg::channel_value(r_first_color, r_channel_layout[24:20],
                    r_channel_layout[29:25], w_diag, r_color_step);
        end else begin
            n_pixel_color = (r_first_color + w_sum) & gtpg_pkg::low_mask(r_bits_per_pixel);
        end

        // advance the walk
        n_x_in_cell   = w_x;
        n_y_in_cell   = w_y;
        n_cell_column = w_col;
        n_cell_row    = w_row;
        n_origin_x    = w_ox;
        n_origin_y    = w_oy;
        n_index_sum   = w_sum;
        if (!w_x_end) begin
            n_x_in_cell = w_x + CLW'(1);
        end else begin
            n_x_in_cell = '0;
            if (!w_y_end) begin
                n_y_in_cell = w_y + CLW'(1);
            end else begin
                n_y_in_cell = '0;
                if (!w_c_end) begin
                    n_cell_column = w_col + CNW'(1);
                    n_origin_x    = w_ox + CW'(r_cell_width);
                    n_index_sum   = w_sum + 32'(r_color_step);
                end else begin
                    n_cell_column = '0;
                    n_origin_x    = '0;
                    if (!w_r_end) begin
                        n_cell_row  = w_row + CNW'(1);
                        n_origin_y  = w_oy + CW'(r_cell_height);
                        n_index_sum = w_sum + 32'(r_color_step);
                    end else begin
                        n_cell_row  = '0;
                        n_origin_y  = '0;
                        n_index_sum = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_in_cell   <= '0;
            r_y_in_cell   <= '0;
            r_cell_column <= '0;
            r_cell_row    <= '0;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_index_sum   <= '0;
            r_out_valid   <= 1'b0;
        end else if (w_accept) begin
            r_x_in_cell   <= n_x_in_cell;
            r_y_in_cell   <= n_y_in_cell;
            r_cell_column <= n_cell_column;
            r_cell_row    <= n_cell_row;
            r_origin_x    <= n_origin_x;
            r_origin_y    <= n_origin_y;
            r_index_sum   <= n_index_sum;
            r_out_valid   <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid   <= 1'b0;
        end
    end

    // hold the pixel until its transaction completes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel_x     <= n_pixel_x;
            r_pixel_y     <= n_pixel_y;
            r_pixel_color <= n_pixel_color;
            r_frame_last  <= n_frame_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_pixel_color, 16'(r_pixel_y), 16'(r_pixel_x)};
    assign m_axis_tlast  = r_frame_last;

`include "grid_test_pattern_generator_core_macros.svh"

    `GTPG_ASSERT_NEXT(a_frame_end_wraps, w_accept && n_frame_last, r_x_in_cell == '0 && r_y_in_cell == '0 && r_cell_column == '0 && r_cell_row == '0 && r_index_sum == '0)
    `GTPG_ASSERT_NOW(a_col0_origin, r_cell_column == '0, r_origin_x == '0)
    `GTPG_ASSERT_NOW(a_row0_origin, r_cell_row == '0, r_origin_y == '0)
    `GTPG_ASSERT_NOW(a_first_cell_sum, r_cell_column == '0 && r_cell_row == '0, r_index_sum == '0)

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic [15:0]                  x;
        logic [15:0]                  y;
        logic [gtpg_pkg::COLOR_W-1:0] color;
        logic                         last;
    } t_pixel;

    // Tracks the grid walk and holds the pixels still owed by the block.
    class pixel_scoreboard;
        logic [gtpg_pkg::CELL_W-1:0]      cell_w, cell_h;
        logic [gtpg_pkg::COUNT_W-1:0]     rects;
        logic [gtpg_pkg::COLOR_W-1:0]     first_color;
        logic [gtpg_pkg::STEP_W-1:0]      step;
        logic                             direct;
        logic [gtpg_pkg::BPP_W-1:0]       bpp;
        logic [gtpg_pkg::LAYOUT_W-1:0]    layout;
        logic [gtpg_pkg::CELL_W-1:0]      x_in_cell, y_in_cell;
        logic [gtpg_pkg::COUNT_W-1:0]     column, row;
        logic [gtpg_pkg::COORD_WIDTH-1:0] origin_x, origin_y;
        logic [gtpg_pkg::COLOR_W-1:0]     index_sum;
        t_pixel                           expected_q[$];
        int                               errors;

        function new();
            cell_w      = 1;
            cell_h      = 1;
            rects       = 1;
            first_color = 0;
            step        = 0;
            direct      = 0;
            bpp         = 8;
            layout      = 0;
            errors      = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            x_in_cell = 0;
            y_in_cell = 0;
            column    = 0;
            row       = 0;
            origin_x  = 0;
            origin_y  = 0;
            index_sum = 0;
        endfunction

        function void set_reg(gtpg_pkg::t_cfg_index idx, logic [31:0] v);
            case (idx)
                gtpg_pkg::CFG_CELL_WIDTH:     cell_w      = v[gtpg_pkg::CELL_W-1:0];
                gtpg_pkg::CFG_CELL_HEIGHT:    cell_h      = v[gtpg_pkg::CELL_W-1:0];
                gtpg_pkg::CFG_RECT_COUNT:     rects       = v[gtpg_pkg::COUNT_W-1:0];
                gtpg_pkg::CFG_FIRST_COLOR:    first_color = v;
                gtpg_pkg::CFG_COLOR_STEP:     step        = v[gtpg_pkg::STEP_W-1:0];
                gtpg_pkg::CFG_DIRECT_MODE:    direct      = v[0];
                gtpg_pkg::CFG_BITS_PER_PIXEL: bpp         = v[gtpg_pkg::BPP_W-1:0];
                gtpg_pkg::CFG_CHANNEL_LAYOUT: layout      = v[gtpg_pkg::LAYOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] ones_below(int unsigned n);
            if (n >= 32) return '1;
            return (32'd1 << n) - 32'd1;
        endfunction

        // Pull one channel out of the first color, add its offset, put it back.
        function logic [31:0] channel(int unsigned slot, int unsigned offset);
            logic [4:0]  size;
            logic [4:0]  pos;
            logic [31:0] m;
            logic [31:0] v;
            size = layout[slot*10 +: 5];
            pos  = layout[slot*10+5 +: 5];
            m    = ones_below(size);
            v    = (((first_color >> pos) & m) + offset * 32'(step)) & m;
            return v << pos;
        endfunction

        function logic [31:0] cell_color();
            if (direct) begin
                return channel(0, 32'(column)) | channel(1, 32'(row)) |
                       channel(2, 32'(row) + 32'(column));
            end
            return (first_color + index_sum) & ones_below(bpp);
        endfunction

        function void note_request(bit restart);
            t_pixel p;
            bit     x_end, y_end, c_end, r_end;
            if (restart) clear_walk();
            // greater-or-equal so a zero or lowered size ends the run at once
            x_end = 32'(x_in_cell) + 32'd1 >= 32'(cell_w);
            y_end = 32'(y_in_cell) + 32'd1 >= 32'(cell_h);
            c_end = 32'(column) + 32'd1 >= 32'(rects);
            r_end = 32'(row) + 32'd1 >= 32'(rects);
            p.x     = origin_x + x_in_cell;
            p.y     = origin_y + y_in_cell;
            p.color = cell_color();
            p.last  = x_end && y_end && c_end && r_end;
            expected_q.push_back(p);

            if (!x_end) begin
                x_in_cell = x_in_cell + 1'b1;
            end else begin
                x_in_cell = 0;
                if (!y_end) begin
                    y_in_cell = y_in_cell + 1'b1;
                end else begin
                    y_in_cell = 0;
                    if (!c_end) begin
                        column    = column + 1'b1;
                        origin_x  = origin_x + cell_w;
                        index_sum = index_sum + step;
                    end else begin
                        column   = 0;
                        origin_x = 0;
                        if (!r_end) begin
                            row       = row + 1'b1;
                            origin_y  = origin_y + cell_h;
                            index_sum = index_sum + step;
                        end else begin
                            row       = 0;
                            origin_y  = 0;
                            index_sum = 0;
                        end
                    end
                end
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_q.size() == 0) begin
                $error("unexpected pixel transaction: x=%0d y=%0d", got.x, got.y);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x) begin
                $error("pixel_x mismatch: expected %0d, actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("pixel_y mismatch: expected %0d, actual %0d", want.y, got.y);
                errors++;
            end
            if (got.color !== want.color) begin
                $error("pixel_color mismatch: expected %h, actual %h", want.color, got.color);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("frame_last mismatch: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [gtpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [gtpg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;   // [0] restart
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [63:0]                     m_axis_tdata;        // [15:0] x, [31:16] y, [63:32] color
    logic                            m_axis_tlast;        // frame_last

    pixel_scoreboard sb;
    bit              idle_on = 1'b1;
    int              ready_stall = 0;
    int unsigned     cycle_count = 0;

    grid_test_pattern_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Pixel side: check each transaction, then pick the next ready value.
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x     = m_axis_tdata[15:0];
            got.y     = m_axis_tdata[31:16];
            got.color = m_axis_tdata[63:32];
            got.last  = m_axis_tlast;
            sb.check_pixel(got);
        end
        if (ready_stall > 0) begin
            ready_stall   <= ready_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_stall   <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(gtpg_pkg::t_cfg_index idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_grid(logic [31:0] w, logic [31:0] h, logic [31:0] cnt,
                                logic [31:0] first, logic [31:0] step, logic [31:0] direct,
                                logic [31:0] bpp, logic [31:0] layout);
        write_reg(gtpg_pkg::CFG_CELL_WIDTH, w);
        write_reg(gtpg_pkg::CFG_CELL_HEIGHT, h);
        write_reg(gtpg_pkg::CFG_RECT_COUNT, cnt);
        write_reg(gtpg_pkg::CFG_FIRST_COLOR, first);
        write_reg(gtpg_pkg::CFG_COLOR_STEP, step);
        write_reg(gtpg_pkg::CFG_DIRECT_MODE, direct);
        write_reg(gtpg_pkg::CFG_BITS_PER_PIXEL, bpp);
        write_reg(gtpg_pkg::CFG_CHANNEL_LAYOUT, layout);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(bit restart);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(restart);
    endtask

    // Hold the request side until every owed pixel has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size(int unsigned big);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(5, big);
        return $urandom_range(1, 4);
    endfunction

    task automatic random_grid();
        logic [31:0] cnt;
        logic [31:0] bpp;
        logic [31:0] layout;
        cnt = pick_size(255);
        if (cnt > 5 && $urandom_range(0, 1)) cnt = 255;
        bpp = $urandom_range(0, 1) ? $urandom_range(0, 63) : 8 * $urandom_range(1, 4);
        // half the time a plain 8:8:8 layout, else any overlap or overflow
        layout = $urandom_range(0, 1) ? {2'b0, 5'd0, 5'd8, 5'd8, 5'd8, 5'd16, 5'd8}
                                      : {2'b0, 30'($urandom)};
        program_grid(pick_size(4095), pick_size(4095), cnt, $urandom, $urandom,
                     $urandom, bpp, layout);
    endtask

    initial begin
        int n;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, restart in the middle
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();

        // full 2x2 frame and its wrap, widest indexed color
        program_grid(1, 2, 2, 32'hFFFF_FFFF, 8'hFF, 0, 32, 0);
        for (int i = 0; i < 9; i++) send_request(1'b0);
        wait_drained();

        // overlapping channels, bits pushed past the top of the word
        program_grid(3, 1, 2, 32'h8040_20FF, 8'h81, 1, 0,
                     {2'b0, 5'd30, 5'd24, 5'd12, 5'd31, 5'd28, 5'd9});
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();

        // zero sizes act as one; bpp above 32
        program_grid(0, 0, 0, $urandom, 8'h01, 0, 63, 0);
        for (int i = 0; i < 3; i++) send_request(1'b0);
        wait_drained();

        // largest grid
        program_grid(4095, 4095, 255, 32'h0000_0001, 8'hFF, 1, 32,
                     {2'b0, 5'd0, 5'd5, 5'd5, 5'd6, 5'd11, 5'd5});
        for (int i = 0; i < 3; i++) send_request(1'b0);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            idle_on = (ph < 10);
            random_grid();
            n = $urandom_range(90, 160);
            for (int i = 0; i < n; i++) send_request($urandom_range(0, 63) == 0);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
